FILE: rtl/prq_pkg.sv
`timescale 1ns / 1ps

package prq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_W    = 8;
  localparam int PRIO_W      = 8;
  localparam int KEY_W       = 16;
  localparam int POLICY_W    = 2;

  // Service policy codes
  typedef enum logic [POLICY_W-1:0] {
    POLICY_FCFS  = 2'd0,
    POLICY_RR    = 2'd1,
    POLICY_PRIO  = 2'd2,
    POLICY_SJN   = 2'd3
  } policy_t;

  // Request command codes
  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  // Contents of one queue cell
  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
  } cell_t;

  // Operation broadcast to every cell in a cycle
  typedef struct packed {
    logic                insert;
    logic                fetch;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
  } cell_op_t;

endpackage

FILE: rtl/prq_in_if.sv
`timescale 1ns / 1ps

interface prq_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [prq_pkg::HANDLE_W-1:0]   process_id;
  logic [prq_pkg::PRIO_W-1:0]     priority_req;
  logic [prq_pkg::KEY_W-1:0]      run_len;

  modport source (output valid, command, process_id, priority_req, run_len,
                  input ready);
  modport sink   (input valid, command, process_id, priority_req, run_len,
                  output ready);
endinterface

FILE: rtl/prq_out_if.sv
`timescale 1ns / 1ps

interface prq_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [prq_pkg::HANDLE_W-1:0]   next_id;
  logic                           overflow;
  logic                           queue_empty;

  modport source (output valid, found, next_id, overflow, queue_empty,
                  input ready);
  modport sink   (input valid, found, next_id, overflow, queue_empty,
                  output ready);
endinterface

FILE: rtl/prq_cell.sv
`timescale 1ns / 1ps

module prq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  prq_pkg::cell_op_t op,
  input  prq_pkg::cell_t    left,
  input  logic              left_moves,
  input  prq_pkg::cell_t    right,
  output prq_pkg::cell_t    q,
  output logic              moves
);

  prq_pkg::cell_t cell_r;
  prq_pkg::cell_t cell_nxt;

  // A cell yields its place when it is empty or holds a larger key
  assign moves = !(cell_r.valid && (cell_r.key <= op.key));
  assign q     = cell_r;

  // Pick the next content: keep, take the new request, or shift
  always_comb begin
    cell_nxt = cell_r;
    if (op.insert) begin
      if (moves) begin
        if (left_moves) begin
          cell_nxt = left;
        end else begin
          cell_nxt.valid  = 1'b1;
          cell_nxt.handle = op.handle;
          cell_nxt.key    = op.key;
        end
      end
    end else if (op.fetch) begin
      cell_nxt = right;
    end
  end

  // Valid flag clears on reset; payload holds no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
    cell_r.handle <= cell_nxt.handle;
    cell_r.key    <= cell_nxt.key;
  end

endmodule

FILE: rtl/policy_ready_queue_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Carries
// in_chan  sink       command, process_id, priority_req, run_len
// out_chan source     found, next_id, overflow, queue_empty
// cfg_*    write      policy (2 bits)
//
// One request per cycle: every cell compares its key with the new key in
// parallel, and the sorted chain shifts in the same cycle; the result lands
// in the output register on the next edge. A stalled result blocks only
// while it is not taken (in_chan.ready = !out valid || out_chan.ready).
// Reset (rst_n low, synchronous) empties the chain and sets policy to FCFS.

module policy_ready_queue_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  prq_in_if.sink                            in_chan,
  prq_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [prq_pkg::POLICY_W-1:0]      cfg_wdata
);

  localparam int D = prq_pkg::QUEUE_DEPTH;

  prq_pkg::policy_t  policy_r;
  prq_pkg::cell_t    cells   [D];
  logic              moves   [D];
  prq_pkg::cell_op_t op;
  prq_pkg::cell_t    empty_cell;
  logic              accept;
  logic              is_fetch;
  logic              full;
  logic [prq_pkg::KEY_W-1:0] key;

  logic                           out_valid_r, out_valid_nxt;
  logic                           found_r, found_nxt;
  logic [prq_pkg::HANDLE_W-1:0]   next_id_r, next_id_nxt;
  logic                           overflow_r, overflow_nxt;
  logic                           empty_r, empty_nxt;

  // Policy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= prq_pkg::POLICY_FCFS;
    end else if (cfg_we) begin
      policy_r <= prq_pkg::policy_t'(cfg_wdata);
    end
  end

  // Build the sort key for the current policy
  always_comb begin
    case (policy_r)
      prq_pkg::POLICY_PRIO: key = {{(prq_pkg::KEY_W-prq_pkg::PRIO_W){1'b0}},
                                   ~in_chan.priority_req};
      prq_pkg::POLICY_SJN:  key = in_chan.run_len;
      default:              key = '0;
    endcase
  end

  assign accept   = in_chan.valid && in_chan.ready;
  assign is_fetch = (in_chan.command == prq_pkg::CMD_FETCH);
  assign full     = cells[D-1].valid;
  assign in_chan.ready = !out_valid_r || out_chan.ready;

  assign empty_cell = '0;

  // Broadcast the operation to the chain
  always_comb begin
    op.insert = accept && !is_fetch && !full;
    op.fetch  = accept && is_fetch;
    op.handle = in_chan.process_id;
    op.key    = key;
  end

  // Chain of sorted cells, head at index zero
  for (genvar i = 0; i < D; i++) begin : g_cell
    prq_pkg::cell_t left_c;
    prq_pkg::cell_t right_c;
    logic           left_m;
    if (i == 0) begin : g_head
      assign left_c = empty_cell;
      assign left_m = 1'b0;
    end else begin : g_mid
      assign left_c = cells[i-1];
      assign left_m = moves[i-1];
    end
    if (i == D-1) begin : g_tail
      assign right_c = empty_cell;
    end else begin : g_body
      assign right_c = cells[i+1];
    end
    prq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .left       (left_c),
      .left_moves (left_m),
      .right      (right_c),
      .q          (cells[i]),
      .moves      (moves[i])
    );
  end

  // Form the result of the accepted request
  always_comb begin
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    next_id_nxt   = next_id_r;
    overflow_nxt  = overflow_r;
    empty_nxt     = empty_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (is_fetch) begin
        found_nxt    = cells[0].valid;
        next_id_nxt  = cells[0].valid ? cells[0].handle : '0;
        overflow_nxt = 1'b0;
        empty_nxt    = !cells[1].valid;
      end else begin
        found_nxt    = 1'b0;
        next_id_nxt  = '0;
        overflow_nxt = full;
        empty_nxt    = 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r    <= found_nxt;
    next_id_r  <= next_id_nxt;
    overflow_r <= overflow_nxt;
    empty_r    <= empty_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = found_r;
  assign out_chan.next_id     = next_id_r;
  assign out_chan.overflow    = overflow_r;
  assign out_chan.queue_empty = empty_r;

endmodule
